// ===== hw/rtl/pfbt_pkg.sv =====
// Shared types and constants of the page frame buffer text blitter.
`timescale 1ns / 1ps

package pfbt_pkg;

    // Command codes carried in the func field.
    typedef enum logic [2:0] {
        FN_FILL   = 3'd0,
        FN_PLOT   = 3'd1,
        FN_CURSOR = 3'd2,
        FN_GLYPH  = 3'd3,
        FN_READ   = 3'd4
    } t_func;

    // Result status codes.
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_SKIP   = 2'd2;

    // Configuration register indexes and port widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_ENABLE  = 2'd2;

    // Register reset values.
    localparam logic [4:0] GLYPH_W_RST = 5'd7;
    localparam logic [6:0] GLYPH_H_RST = 7'd10;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_DRAW,
        S_READ,
        S_FILL
    } t_state;

    typedef struct packed {
        t_func       func;
        logic [6:0]  pos_x;
        logic [5:0]  pos_y;
        logic        ink;
        logic [15:0] row_bits;
        logic [5:0]  row_index;
        logic        start_of_string;
    } t_cmd;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] status;
    } t_res;

endpackage

// ===== hw/rtl/page_framebuffer_text_blitter_core.sv =====
// Top level of the page frame buffer text blitter: command decode, glyph blit and frame store.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                Word
//  -------   ---------  -----------------------  ------------------------------------------
//  command   in         start high, busy low     i_cmd  (func, position, ink, glyph row)
//  result    out        o_valid, one cycle only  o_res  (read_data, status)
//  config    in         i_cfg_we, no wait        i_cfg_idx, i_cfg_data
//
// A glyph row is first decoded; then one frame byte per column goes through a
// read, modify and write pipeline on the single frame store, and a final drain
// step writes back the last column. A fill writes every frame byte in turn.
// After reset the block clears the frame store, one byte per cycle (1024 bytes
// at the default size), with busy held high; configuration writes are taken
// during that time. The result word appears for exactly one cycle, in the
// cycle after the work ends; the receiver cannot stall it.

module page_framebuffer_text_blitter_core #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64,
    parameter int GLYPH_BITS    = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  pfbt_pkg::t_cmd                    i_cmd,
    output logic                              o_valid,
    output pfbt_pkg::t_res                    o_res,
    input  logic                              i_cfg_we,
    input  logic [pfbt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pfbt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int DEPTH  = (SCREEN_WIDTH * SCREEN_HEIGHT) / 8;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PAGES  = SCREEN_HEIGHT / 8;

    // Control state.
    pfbt_pkg::t_state     r_state, n_state;
    logic                 r_valid, n_valid;
    logic [4:0]           r_glyph_w, n_glyph_w;
    logic [6:0]           r_glyph_h, n_glyph_h;
    logic                 r_wrap_en, n_wrap_en;
    logic [7:0]           r_cursor_x, n_cursor_x;
    logic [7:0]           r_cursor_y, n_cursor_y;
    logic [7:0]           r_start_x, n_start_x;
    logic [7:0]           r_start_y, n_start_y;
    logic [7:0]           r_wrap_cnt, n_wrap_cnt;
    logic                 r_abort, n_abort;
    logic [ADDR_W-1:0]    r_sweep, n_sweep;
    logic [7:0]           r_fill_byte, n_fill_byte;
    logic                 r_s1_valid, n_s1_valid;

    // Working registers of the current command.
    pfbt_pkg::t_cmd       r_cmd, n_cmd;
    pfbt_pkg::t_res       r_res, n_res;
    logic [8:0]           r_cx, n_cx;
    logic                 r_yok, n_yok;
    logic [2:0]           r_ybit, n_ybit;
    logic [ADDR_W-1:0]    r_base, n_base;
    logic [GLYPH_BITS-1:0] r_pattern, n_pattern;
    logic [4:0]           r_col, n_col;
    logic [4:0]           r_ncol, n_ncol;
    logic                 r_adv, n_adv;
    logic [ADDR_W-1:0]    r_s1_addr, n_s1_addr;
    logic                 r_s1_set, n_s1_set;

    // Frame store port signals.
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [7:0]           ram_wdata;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [7:0]           ram_rdata;
    logic [7:0]           bit_mask;

    // Text cursor decisions for a glyph row.
    logic                 g_sos;
    logic [7:0]           g_start_x, g_start_y, g_wc;
    logic                 g_abort_in;
    logic [8:0]           g_x_sum, g_y_sum;
    logic                 g_x_full, g_y_full;
    logic [14:0]          g_prod;
    logic [7:0]           g_wrap_y;
    logic                 g_first, g_wrap, g_reject, g_in_range;
    logic [7:0]           g_cx, g_cy;

    // Drawing origin and byte read address.
    logic                 is_plot;
    logic [8:0]           d_x9, d_y9;
    logic                 d_yok;
    logic [ADDR_W-1:0]    d_base;
    logic                 rd_ok;
    logic [ADDR_W-1:0]    rd_addr;

    pfbt_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy    = (r_state != pfbt_pkg::S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // The string start takes effect before the abort flag is looked at, and
    // a wrap returns to the freshly copied start position.
    always_comb begin
        g_sos      = (r_cmd.row_index == 6'd0) && r_cmd.start_of_string;
        g_start_x  = g_sos ? r_cursor_x : r_start_x;
        g_start_y  = g_sos ? r_cursor_y : r_start_y;
        g_wc       = g_sos ? 8'd1 : r_wrap_cnt;
        g_abort_in = !g_sos && r_abort;
        g_x_sum    = {1'b0, r_cursor_x} + {4'd0, r_glyph_w};
        g_y_sum    = {1'b0, r_cursor_y} + {2'd0, r_glyph_h};
        g_x_full   = (g_x_sum >= 9'(SCREEN_WIDTH));
        g_y_full   = (g_y_sum >= 9'(SCREEN_HEIGHT));
        g_prod     = 15'(r_glyph_h) * 15'(g_wc);
        g_wrap_y   = g_start_y + g_prod[7:0];
        g_first    = (r_cmd.row_index == 6'd0);
        g_wrap     = g_first && r_wrap_en && g_x_full;
        g_reject   = g_first && !g_wrap && (g_x_full || g_y_full);
        g_in_range = ({1'b0, r_cmd.row_index} < r_glyph_h);
        g_cx       = g_wrap ? g_start_x : r_cursor_x;
        g_cy       = g_wrap ? g_wrap_y : r_cursor_y;
    end

    // A plot is drawn as a one-column glyph row whose only bit is set.
    always_comb begin
        is_plot = (r_cmd.func == pfbt_pkg::FN_PLOT);
        d_x9    = is_plot ? {2'd0, r_cmd.pos_x} : {1'b0, g_cx};
        d_y9    = is_plot ? {3'd0, r_cmd.pos_y} : ({1'b0, g_cy} + {3'd0, r_cmd.row_index});
        d_yok   = (d_y9 < 9'(SCREEN_HEIGHT));
        d_base  = ADDR_W'(d_y9[8:3]) * ADDR_W'(SCREEN_WIDTH);
        rd_ok   = (r_cmd.pos_y < 6'(PAGES)) && ({2'd0, r_cmd.pos_x} < 9'(SCREEN_WIDTH));
        rd_addr = ADDR_W'(r_cmd.pos_y) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(r_cmd.pos_x);
    end

    assign bit_mask = 8'b1 << r_ybit;

    always_comb begin
        n_state     = r_state;
        n_valid     = 1'b0;
        n_res       = r_res;
        n_glyph_w   = r_glyph_w;
        n_glyph_h   = r_glyph_h;
        n_wrap_en   = r_wrap_en;
        n_cursor_x  = r_cursor_x;
        n_cursor_y  = r_cursor_y;
        n_start_x   = r_start_x;
        n_start_y   = r_start_y;
        n_wrap_cnt  = r_wrap_cnt;
        n_abort     = r_abort;
        n_sweep     = r_sweep;
        n_fill_byte = r_fill_byte;
        n_s1_valid  = 1'b0;
        n_cmd       = r_cmd;
        n_cx        = r_cx;
        n_yok       = r_yok;
        n_ybit      = r_ybit;
        n_base      = r_base;
        n_pattern   = r_pattern;
        n_col       = r_col;
        n_ncol      = r_ncol;
        n_adv       = r_adv;
        n_s1_addr   = r_s1_addr;
        n_s1_set    = r_s1_set;
        ram_re      = 1'b0;
        ram_raddr   = rd_addr;
        ram_we      = 1'b0;
        ram_waddr   = r_s1_addr;
        ram_wdata   = r_s1_set ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);

        // Write stage of the read, modify and write pipeline.
        if (r_s1_valid) begin
            ram_we = 1'b1;
        end

        unique case (r_state)
            pfbt_pkg::S_CLEAR, pfbt_pkg::S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_sweep;
                ram_wdata = r_fill_byte;
                if (r_sweep == ADDR_W'(DEPTH - 1)) begin
                    n_state = pfbt_pkg::S_IDLE;
                    if (r_state == pfbt_pkg::S_FILL) begin
                        n_valid          = 1'b1;
                        n_res.read_data  = 8'd0;
                        n_res.status     = pfbt_pkg::ST_DONE;
                    end
                end else begin
                    n_sweep = r_sweep + ADDR_W'(1);
                end
            end

            pfbt_pkg::S_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_state = pfbt_pkg::S_CHECK;
                end
            end

            pfbt_pkg::S_CHECK: begin
                n_res.read_data = 8'd0;
                n_res.status    = pfbt_pkg::ST_DONE;
                n_cx            = d_x9;
                n_yok           = d_yok;
                n_ybit          = d_y9[2:0];
                n_base          = d_base;
                n_col           = 5'd0;
                unique case (r_cmd.func)
                    pfbt_pkg::FN_FILL: begin
                        n_fill_byte = {8{r_cmd.ink}};
                        n_sweep     = '0;
                        n_state     = pfbt_pkg::S_FILL;
                    end
                    pfbt_pkg::FN_PLOT: begin
                        n_ncol    = 5'd1;
                        n_pattern = '1;
                        n_adv     = 1'b0;
                        n_state   = pfbt_pkg::S_DRAW;
                    end
                    pfbt_pkg::FN_CURSOR: begin
                        n_cursor_x = {1'b0, r_cmd.pos_x};
                        n_cursor_y = {2'd0, r_cmd.pos_y};
                        n_start_x  = {1'b0, r_cmd.pos_x};
                        n_start_y  = {2'd0, r_cmd.pos_y};
                        n_valid    = 1'b1;
                        n_state    = pfbt_pkg::S_IDLE;
                    end
                    pfbt_pkg::FN_GLYPH: begin
                        n_start_x  = g_start_x;
                        n_start_y  = g_start_y;
                        n_wrap_cnt = g_wc;
                        n_abort    = g_abort_in;
                        if (g_abort_in) begin
                            n_res.status = pfbt_pkg::ST_SKIP;
                            n_valid      = 1'b1;
                            n_state      = pfbt_pkg::S_IDLE;
                        end else if (!g_in_range) begin
                            n_valid = 1'b1;
                            n_state = pfbt_pkg::S_IDLE;
                        end else if (g_reject) begin
                            n_abort      = 1'b1;
                            n_res.status = pfbt_pkg::ST_REJECT;
                            n_valid      = 1'b1;
                            n_state      = pfbt_pkg::S_IDLE;
                        end else begin
                            if (g_wrap) begin
                                n_wrap_cnt = g_wc + 8'd1;
                            end
                            n_cursor_x = g_cx;
                            n_cursor_y = g_cy;
                            n_ncol     = r_glyph_w;
                            n_pattern  = r_cmd.row_bits[GLYPH_BITS-1:0];
                            n_adv      = ({1'b0, r_cmd.row_index} == (r_glyph_h - 7'd1));
                            n_state    = pfbt_pkg::S_DRAW;
                        end
                    end
                    pfbt_pkg::FN_READ: begin
                        if (rd_ok) begin
                            ram_re  = 1'b1;
                            n_state = pfbt_pkg::S_READ;
                        end else begin
                            n_valid = 1'b1;
                            n_state = pfbt_pkg::S_IDLE;
                        end
                    end
                    default: begin
                        n_valid = 1'b1;
                        n_state = pfbt_pkg::S_IDLE;
                    end
                endcase
            end

            pfbt_pkg::S_DRAW: begin
                if (r_col != r_ncol) begin
                    if ((r_cx < 9'(SCREEN_WIDTH)) && r_yok) begin
                        ram_re     = 1'b1;
                        ram_raddr  = r_base + ADDR_W'(r_cx);
                        n_s1_valid = 1'b1;
                        n_s1_addr  = r_base + ADDR_W'(r_cx);
                        n_s1_set   = ~(r_pattern[GLYPH_BITS-1] ^ r_cmd.ink);
                    end
                    n_cx      = r_cx + 9'd1;
                    n_col     = r_col + 5'd1;
                    n_pattern = {r_pattern[GLYPH_BITS-2:0], 1'b0};
                end else begin
                    // The last column is written back in this cycle.
                    if (r_adv) begin
                        n_cursor_x = r_cursor_x + {3'd0, r_glyph_w};
                    end
                    n_res.read_data = 8'd0;
                    n_res.status    = pfbt_pkg::ST_DONE;
                    n_valid         = 1'b1;
                    n_state         = pfbt_pkg::S_IDLE;
                end
            end

            pfbt_pkg::S_READ: begin
                n_res.read_data = ram_rdata;
                n_res.status    = pfbt_pkg::ST_DONE;
                n_valid         = 1'b1;
                n_state         = pfbt_pkg::S_IDLE;
            end

            default: begin
                n_state = pfbt_pkg::S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_idx)
                pfbt_pkg::CFG_GLYPH_WIDTH:  n_glyph_w = i_cfg_data[4:0];
                pfbt_pkg::CFG_GLYPH_HEIGHT: n_glyph_h = i_cfg_data;
                pfbt_pkg::CFG_WRAP_ENABLE:  n_wrap_en = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfbt_pkg::S_CLEAR;
            r_valid     <= 1'b0;
            r_glyph_w   <= pfbt_pkg::GLYPH_W_RST;
            r_glyph_h   <= pfbt_pkg::GLYPH_H_RST;
            r_wrap_en   <= 1'b0;
            r_cursor_x  <= 8'd0;
            r_cursor_y  <= 8'd0;
            r_start_x   <= 8'd0;
            r_start_y   <= 8'd0;
            r_wrap_cnt  <= 8'd1;
            r_abort     <= 1'b0;
            r_sweep     <= '0;
            r_fill_byte <= 8'd0;
            r_s1_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_glyph_w   <= n_glyph_w;
            r_glyph_h   <= n_glyph_h;
            r_wrap_en   <= n_wrap_en;
            r_cursor_x  <= n_cursor_x;
            r_cursor_y  <= n_cursor_y;
            r_start_x   <= n_start_x;
            r_start_y   <= n_start_y;
            r_wrap_cnt  <= n_wrap_cnt;
            r_abort     <= n_abort;
            r_sweep     <= n_sweep;
            r_fill_byte <= n_fill_byte;
            r_s1_valid  <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_res     <= n_res;
        r_cx      <= n_cx;
        r_yok     <= n_yok;
        r_ybit    <= n_ybit;
        r_base    <= n_base;
        r_pattern <= n_pattern;
        r_col     <= n_col;
        r_ncol    <= n_ncol;
        r_adv     <= n_adv;
        r_s1_addr <= n_s1_addr;
        r_s1_set  <= n_s1_set;
    end

    // A write-back only ever follows a column read of the blit sequence.
    a_s1_from_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> ($past(r_state) == pfbt_pkg::S_DRAW))
        else $error("write-back without a preceding column read");

    // An accepted command is decoded in the following cycle.
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == pfbt_pkg::S_CHECK))
        else $error("accepted command not decoded");

    // A rejected character always leaves the rest of its string skipped.
    a_reject_abort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_res.status == pfbt_pkg::ST_REJECT)) |-> r_abort)
        else $error("rejection without string abort");

    // The byte read cycle must not overlap any store write.
    a_read_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfbt_pkg::S_READ) |-> !ram_we)
        else $error("frame store written during a byte read");

    // A result never comes out of the idle or clearing states.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (($past(r_state) != pfbt_pkg::S_IDLE)
                     && ($past(r_state) != pfbt_pkg::S_CLEAR)))
        else $error("result word without work");

endmodule

// ===== hw/rtl/pfbt_ram.sv =====
// Generic simple dual port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module pfbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/sv/page_framebuffer_text_blitter_core_test.sv =====
// Self-checking testbench for the page frame buffer text blitter core.
`timescale 1ns / 1ps

module page_framebuffer_text_blitter_core_test;

    import pfbt_pkg::*;

    localparam int SCR_W       = 128;
    localparam int SCR_H       = 64;
    localparam int GLYPH_BITS  = 16;
    localparam int STORE_BYTES = SCR_W * SCR_H / 8;

    // Command codes that the block leaves undefined; it must answer them with zero fields.
    localparam logic [2:0] FN_UNUSED_LO = 3'd5;
    localparam logic [2:0] FN_UNUSED_HI = 3'd7;

    // Block interface. Every input holds a known value from time zero.
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    logic                  busy;
    t_cmd                  i_cmd      = '0;
    logic                  o_valid;
    t_res                  o_res;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Predicted image of the frame store and of the text state that drives the blitter.
    logic [7:0] fb_mem [0:STORE_BYTES-1];
    int         cur_x    = 0;
    int         cur_y    = 0;
    int         org_x    = 0;
    int         org_y    = 0;
    int         line_no  = 1;
    bit         str_dead = 1'b0;

    // Predicted register contents, starting from their reset values.
    int         cfg_gw   = int'(GLYPH_W_RST);
    int         cfg_gh   = int'(GLYPH_H_RST);
    bit         cfg_wrap = 1'b0;

    // Result words still owed by the block, oldest first.
    t_res       pending_results [$];
    int         words_sent = 0;
    int         errors     = 0;
    int         gap_pct    = 0;

    page_framebuffer_text_blitter_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .o_valid    (o_valid),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        for (int k = 0; k < STORE_BYTES; k++) begin
            fb_mem[k] = 8'h00;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Paints one pixel of the predicted store; anything off the screen is clipped.
    task automatic set_pixel(input int x, input int y, input logic white);
        if (x < SCR_W && y < SCR_H) begin
            fb_mem[(y / 8) * SCR_W + x][y % 8] = white;
        end
    endtask

    // One glyph row: string start, skipping after a rejection, the room check with its
    // optional wrap, the opaque blit and the cursor advance after the last row.
    task automatic blit_row(input t_cmd c, output logic [1:0] st);
        int   j;
        int   y_row;
        bit   x_full;
        bit   y_full;
        logic b;
        st = ST_DONE;
        if (c.row_index == 0 && c.start_of_string) begin
            org_x    = cur_x;
            org_y    = cur_y;
            line_no  = 1;
            str_dead = 1'b0;
        end
        if (str_dead) begin
            st = ST_SKIP;
            return;
        end
        if (c.row_index >= cfg_gh) begin
            return;
        end
        if (c.row_index == 0) begin
            x_full = (cur_x + cfg_gw) >= SCR_W;
            y_full = (cur_y + cfg_gh) >= SCR_H;
            if (cfg_wrap && x_full) begin
                // No second height check after a wrap: the character may land off screen.
                cur_x   = org_x;
                cur_y   = (org_y + cfg_gh * line_no) & 255;
                line_no = (line_no + 1) & 255;
            end else if (x_full || y_full) begin
                str_dead = 1'b1;
                st       = ST_REJECT;
                return;
            end
        end
        y_row = cur_y + c.row_index;
        for (j = 0; j < cfg_gw; j++) begin
            // Columns past the glyph bitmap behave as clear bits.
            b = (j < GLYPH_BITS) ? c.row_bits[GLYPH_BITS-1-j] : 1'b0;
            set_pixel(cur_x + j, y_row, b ? c.ink : ~c.ink);
        end
        if (c.row_index == cfg_gh - 1) begin
            cur_x = (cur_x + cfg_gw) & 255;
        end
    endtask

    // Applies one accepted command word to the predicted state and yields its result word.
    task automatic frame_apply(input t_cmd c, output t_res r);
        logic [1:0] st;
        r = '0;
        case (c.func)
            FN_FILL: begin
                for (int k = 0; k < STORE_BYTES; k++) begin
                    fb_mem[k] = c.ink ? 8'hFF : 8'h00;
                end
            end
            FN_PLOT: begin
                set_pixel(c.pos_x, c.pos_y, c.ink);
            end
            FN_CURSOR: begin
                cur_x = c.pos_x;
                cur_y = c.pos_y;
                org_x = c.pos_x;
                org_y = c.pos_y;
            end
            FN_GLYPH: begin
                blit_row(c, st);
                r.status = st;
            end
            FN_READ: begin
                // Pages past the bottom of the screen read as zero.
                if (c.pos_y < SCR_H / 8) begin
                    r.read_data = fb_mem[c.pos_y * SCR_W + c.pos_x];
                end
            end
            default: begin
            end
        endcase
    endtask

    function automatic t_cmd mk(input t_func f, input int x, input int y, input int pen,
                                input int bits, input int row, input int sos);
        t_cmd c;
        c.func            = f;
        c.pos_x           = x[6:0];
        c.pos_y           = y[5:0];
        c.ink             = pen[0];
        c.row_bits        = bits[15:0];
        c.row_index       = row[5:0];
        c.start_of_string = sos[0];
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Lowers start for a burst of idle cycles. Half the time the burst only begins once
    // the block has gone idle, so that gaps land both inside and after its work.
    task automatic hold_off(input int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        if ($urandom_range(0, 1) == 1) begin
            @(posedge i_clk);
            while (busy !== 1'b0) @(posedge i_clk);
        end
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Offers one command word and returns at the edge that takes it. Start is left high,
    // so a following word goes out back to back; hold_off or settle lowers it.
    task automatic send_word(input t_cmd c);
        t_res r;
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            hold_off($urandom_range(1, 9));
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        frame_apply(c, r);
        pending_results.push_back(r);
        words_sent++;
    endtask

    // Brings the block to rest: no word offered, every result back, a few spare cycles.
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_GLYPH_WIDTH:  cfg_gw   = val & 31;
            CFG_GLYPH_HEIGHT: cfg_gh   = val & 127;
            CFG_WRAP_ENABLE:  cfg_wrap = val[0];
            default: begin
            end
        endcase
    endtask

    task automatic configure(input int gw, input int gh, input int wrap_on);
        settle();
        write_reg(CFG_GLYPH_WIDTH, gw);
        write_reg(CFG_GLYPH_HEIGHT, gh);
        write_reg(CFG_WRAP_ENABLE, wrap_on);
    endtask

    // ------------------------------------------------------------------
    // Result checking: every strobed word is matched against the oldest prediction.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word: expected none, actual %h", $time, o_res);
            end else begin
                want = pending_results.pop_front();
                if (o_res.read_data !== want.read_data) begin
                    errors++;
                    $display("%0t: read_data mismatch: expected %02h, actual %02h",
                             $time, want.read_data, o_res.read_data);
                end
                if (o_res.status !== want.status) begin
                    errors++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, o_res.status);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // The store must come out of its clearing pass all zero.
    task automatic test_power_on_clear();
        send_word(mk(FN_READ, 0, 0, 0, 0, 0, 0));
        send_word(mk(FN_READ, SCR_W - 1, SCR_H / 8 - 1, 0, 0, 0, 0));
        send_word(mk(FN_READ, 64, 3, 1, 16'hFFFF, 63, 1));
    endtask

    // Fill both ways, plotting at the corners, reads off the bottom and the unused codes.
    task automatic test_fill_plot_read();
        send_word(mk(FN_FILL, 0, 0, 1, 0, 0, 0));
        send_word(mk(FN_READ, SCR_W - 1, SCR_H / 8 - 1, 0, 0, 0, 0));
        send_word(mk(FN_PLOT, SCR_W - 1, SCR_H - 1, 0, 0, 0, 0));
        send_word(mk(FN_READ, SCR_W - 1, SCR_H / 8 - 1, 0, 0, 0, 0));
        send_word(mk(FN_PLOT, 0, 0, 0, 0, 0, 0));
        send_word(mk(FN_READ, 0, 0, 0, 0, 0, 0));
        send_word(mk(FN_READ, 5, SCR_H / 8, 0, 0, 0, 0));
        send_word(mk(t_func'(FN_UNUSED_LO), 127, 63, 1, 16'hFFFF, 63, 1));
        send_word(mk(t_func'(FN_UNUSED_HI), 127, 63, 1, 16'hFFFF, 0, 1));
        send_word(mk(FN_FILL, 0, 0, 0, 0, 0, 0));
    endtask

    // A cell wider than the bitmap: the columns past bit zero are painted as background.
    // A row index past the cell height is dropped.
    task automatic test_glyph_columns();
        configure(20, 2, 0);
        send_word(mk(FN_CURSOR, 0, 0, 0, 0, 0, 0));
        send_word(mk(FN_GLYPH, 0, 0, 1, 16'h8001, 0, 1));
        send_word(mk(FN_GLYPH, 0, 0, 0, 16'hFFFF, 1, 0));
        send_word(mk(FN_GLYPH, 0, 0, 1, 16'hFFFF, 63, 0));
        send_word(mk(FN_READ, 0, 0, 0, 0, 0, 0));
        send_word(mk(FN_READ, 15, 0, 0, 0, 0, 0));
        send_word(mk(FN_READ, 19, 0, 0, 0, 0, 0));
    endtask

    // No room across, then no room down. After a rejection the string is skipped, and a
    // start flag on a later row must not revive it.
    task automatic test_reject_and_skip();
        configure(7, 10, 0);
        send_word(mk(FN_CURSOR, 125, 0, 0, 0, 0, 0));
        send_word(mk(FN_GLYPH, 0, 0, 1, 16'hAAAA, 0, 1));
        send_word(mk(FN_GLYPH, 0, 0, 1, 16'h5555, 1, 0));
        send_word(mk(FN_GLYPH, 0, 0, 1, 16'h5555, 2, 1));
        send_word(mk(FN_CURSOR, 0, 60, 0, 0, 0, 0));
        send_word(mk(FN_GLYPH, 0, 0, 1, 16'hFFFF, 0, 1));
    endtask

    // A wrap back to a start column that is itself full draws clipped one line down.
    // With a cell height of zero every row is ignored.
    task automatic test_wrap_and_empty_height();
        configure(7, 10, 1);
        send_word(mk(FN_CURSOR, 124, 3, 0, 0, 0, 0));
        send_word(mk(FN_GLYPH, 0, 0, 1, 16'hFFFF, 0, 1));
        send_word(mk(FN_READ, 124, 1, 0, 0, 0, 0));
        configure(7, 0, 1);
        send_word(mk(FN_GLYPH, 0, 0, 1, 16'hFFFF, 0, 1));
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly well-formed strings with random glyph rows, each followed
    // by reads of the area just drawn, mixed with fully random command words.
    // ------------------------------------------------------------------

    task automatic test_random_traffic(input int gw, input int gh, input int wrap_on,
                                       input int n_words, input int pct);
        int first;
        int n_chars;
        int rows;
        int row;
        int sos;
        int roll;
        int pen;
        int f;
        configure(gw, gh, wrap_on);
        first = words_sent;
        while (words_sent - first < n_words) begin
            // Some stretches run with no idling at all.
            gap_pct = ($urandom_range(0, 3) == 0) ? 0 : pct;
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 4) != 0) begin
                    // Bias the start towards the right edge so that wraps and rejections occur.
                    send_word(mk(FN_CURSOR,
                                 $urandom_range(0, 1) ? $urandom_range(0, 127)
                                                      : $urandom_range(96, 127),
                                 $urandom_range(0, 63), $urandom, $urandom, $urandom,
                                 $urandom));
                end
                n_chars = $urandom_range(1, (cfg_gh > 20) ? 2 : 10);
                pen     = $urandom_range(0, 1);
                for (int ch = 0; ch < n_chars; ch++) begin
                    rows = (cfg_gh == 0) ? $urandom_range(1, 3) : cfg_gh;
                    for (int r = 0; r < rows; r++) begin
                        row  = r;
                        sos  = (ch == 0 && r == 0);
                        roll = $urandom_range(0, 99);
                        // A few broken sequences: dropped rows, stray indexes, stray flags.
                        if (roll < 2) continue;
                        if (roll < 5) begin
                            row = $urandom_range(0, 63);
                        end else if (roll < 8) begin
                            sos = !sos;
                        end
                        send_word(mk(FN_GLYPH, $urandom, $urandom, pen ^ (roll == 99),
                                     $urandom, row, sos));
                    end
                end
                repeat ($urandom_range(1, 4)) begin
                    send_word(mk(FN_READ, (org_x + $urandom_range(0, 40)) % SCR_W,
                                 ((cur_y + $urandom_range(0, 15)) / 8) % (SCR_H / 8),
                                 $urandom, $urandom, $urandom, $urandom));
                end
            end else begin
                // A fill costs a whole store pass, so it is kept rare.
                f = $urandom_range(0, 7);
                if (f == int'(FN_FILL) && $urandom_range(0, 39) != 0) begin
                    f = int'(FN_READ);
                end
                send_word(mk(t_func'(f[2:0]), $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        gap_pct = 20;
        test_power_on_clear();
        test_fill_plot_read();
        test_glyph_columns();
        test_reject_and_skip();
        test_wrap_and_empty_height();

        test_random_traffic(7, 10, 0, 300, 25);
        test_random_traffic(7, 10, 1, 300, 25);
        test_random_traffic(1, 1, 1, 150, 25);
        test_random_traffic(16, 8, 1, 250, 25);
        test_random_traffic(31, 3, 1, 150, 25);
        test_random_traffic(12, 0, 0, 60, 25);
        test_random_traffic(16, 64, 1, 80, 25);
        test_random_traffic(4, 127, 1, 100, 25);
        // The closing stretch runs without idling.
        test_random_traffic(5, 7, 1, 250, 0);

        settle();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("page_framebuffer_text_blitter_core_test: done, clean");
        end else begin
            $display("page_framebuffer_text_blitter_core_test: done, errors");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("page_framebuffer_text_blitter_core_test: done, errors");
        $finish;
    end

endmodule
